@@ src/irkt_pkg.sv @@
// ----------------------------------------------------------------------------
// irkt_pkg
// Shared types and constants of the ir key press / release tracker.
// ----------------------------------------------------------------------------
package irkt_pkg;

    // widest slot index, enough for the largest supported table of 64 slots
    localparam int SLOT_IDX_W = 6;
    localparam int CNT_W      = SLOT_IDX_W + 1;

    localparam logic [31:0] REPEAT_MARK     = 32'hFFFF_FFFF;
    localparam logic [15:0] RESET_TIMEOUT   = 16'd200;
    localparam logic [15:0] QUIET_MAX       = 16'hFFFF;

    // item kinds
    localparam logic [2:0] KIND_TICK        = 3'd0;
    localparam logic [2:0] KIND_FRAME       = 3'd1;
    localparam logic [2:0] KIND_SET_PRESS   = 3'd2;
    localparam logic [2:0] KIND_SET_RELEASE = 3'd3;
    localparam logic [2:0] KIND_QUERY       = 3'd4;

    // result event codes
    localparam logic [1:0] EV_NONE          = 2'd0;
    localparam logic [1:0] EV_PRESS         = 2'd1;
    localparam logic [1:0] EV_RELEASE       = 2'd2;
    localparam logic [1:0] EV_DROPPED       = 2'd3;

    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;

    // search token that walks the row of cells
    typedef struct packed {
        logic      active;
        logic      found;
        t_slot_idx idx;
    } t_probe;

    // table write, broadcast to all cells
    typedef struct packed {
        logic        set_code;
        logic        set_press;
        logic        set_rel;
        t_slot_idx   idx;
        logic [31:0] code;
        logic        press;
        logic        rel;
    } t_cell_wr;

endpackage

@@ src/irkt_cell.sv @@
// ----------------------------------------------------------------------------
// irkt_cell
// One table slot: code, press and release enables, and one stage of the
// search token that walks the row.
// ----------------------------------------------------------------------------
module irkt_cell import irkt_pkg::*; #(
    parameter t_slot_idx CELL_IDX = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_key,
    input  logic [CNT_W-1:0]  i_used,
    input  t_probe            i_probe,
    output t_probe            o_probe,
    input  t_cell_wr          i_wr,
    output logic              o_press_en,
    output logic              o_rel_en
);

    logic [31:0] r_code;
    logic        r_press;
    logic        r_rel;
    t_probe      r_probe;
    t_probe      n_probe;
    logic        w_hit;
    logic        w_sel;

    // first live slot holding the key claims the token
    always_comb begin
        w_hit = i_probe.active && !i_probe.found
                && (CNT_W'(CELL_IDX) < i_used) && (r_code == i_key);
        n_probe.active = i_probe.active;
        n_probe.found  = i_probe.found | w_hit;
        n_probe.idx    = w_hit ? CELL_IDX : i_probe.idx;
    end

    // only the token's active bit needs a reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.active <= 1'b0;
        end else begin
            r_probe.active <= n_probe.active;
        end
        r_probe.found <= n_probe.found;
        r_probe.idx   <= n_probe.idx;
    end

    assign w_sel = (i_wr.idx == CELL_IDX);

    always_ff @(posedge i_clk) begin
        if (w_sel && i_wr.set_code) begin
            r_code <= i_wr.code;
        end
        if (w_sel && i_wr.set_press) begin
            r_press <= i_wr.press;
        end
        if (w_sel && i_wr.set_rel) begin
            r_rel <= i_wr.rel;
        end
    end

    assign o_probe    = r_probe;
    assign o_press_en = r_press;
    assign o_rel_en   = r_rel;

endmodule

@@ src/ir_key_press_release_tracker.sv @@
// ----------------------------------------------------------------------------
// ir_key_press_release_tracker
// Turns decoded ir remote codes and millisecond ticks into press and release
// events, using a row of slot cells searched by a token that moves one cell
// per cycle.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        slave      i_valid / o_ready    i_kind, i_key_code, i_handler_on
//  out       master     o_valid / i_ready    o_event_res, o_slot, o_action_code,
//                                            o_held_code, o_released_match
//  cfg       slave      i_cfg_we             i_cfg_wdata (release timeout, ms)
//
//  ticks, queries and repeat frames go from accept straight to the finish state
//  frames and registrations first search: the search token walks
//  the SLOTS cells one per cycle before the table is read or written
//  one transaction is worked on at a time; a new one is taken as soon as the
//  previous result is in the output register, even if it is still waiting
//  a stalled output holds the finished transaction in its last state
//  synchronous active-low reset; the table itself is not cleared, only the
//  fill count, so no clearing pass is needed
// ----------------------------------------------------------------------------
module ir_key_press_release_tracker import irkt_pkg::*; #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_key_code,
    input  logic        i_handler_on,
    // result transactions
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_event_res,
    output logic [4:0]  o_slot,
    output logic [31:0] o_action_code,
    output logic [31:0] o_held_code,
    output logic        o_released_match,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // control
    t_state          r_state, n_state;
    logic            r_inject;
    logic            w_accept;
    logic            w_needs_scan;
    logic            w_commit;

    // current transaction
    logic [2:0]      r_kind;
    logic [31:0]     r_key;
    logic            r_on;
    logic            r_found;
    t_slot_idx       r_found_idx;

    // tracker state
    logic [15:0]     r_timeout;
    logic [CW-1:0]   r_used, n_used;
    logic [IW-1:0]   r_held_slot, n_held_slot;
    logic            r_held_valid, n_held_valid;
    logic [31:0]     r_pressed, n_pressed;
    logic [31:0]     r_released, n_released;
    logic [15:0]     r_quiet, n_quiet;

    // output register
    logic            r_out_valid;
    logic [1:0]      r_event_res, n_event_res;
    logic [4:0]      r_slot, n_slot;
    logic [31:0]     r_action_code, n_action_code;
    logic [31:0]     r_held_code;
    logic            r_released_match, n_released_match;

    // cell row
    t_probe          w_probe [0:SLOTS];
    t_cell_wr        w_wr;
    logic [SLOTS-1:0] w_press_en;
    logic [SLOTS-1:0] w_rel_en;
    logic [15:0]     w_quiet_inc;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    // finish only when the output register is free or being emptied
    assign w_commit = (r_state == S_FIN) && (!r_out_valid || i_ready);

    // frames with a real code and registrations need the table search
    assign w_needs_scan = ((i_kind == KIND_FRAME) && (i_key_code != REPEAT_MARK))
                          || (i_kind == KIND_SET_PRESS)
                          || (i_kind == KIND_SET_RELEASE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_needs_scan ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (w_probe[SLOTS].active) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inject <= 1'b0;
        end else begin
            r_state  <= n_state;
            // token enters cell 0 the cycle after accept, once r_key holds the code
            r_inject <= w_accept && w_needs_scan;
        end
    end

    // capture the transaction and the search result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_key  <= i_key_code;
            r_on   <= i_handler_on;
        end
        if (w_accept) begin
            r_found <= 1'b0;
        end else if ((r_state == S_SCAN) && w_probe[SLOTS].active) begin
            r_found     <= w_probe[SLOTS].found;
            r_found_idx <= w_probe[SLOTS].idx;
        end
    end

    // ------------------------------------------------------------------
    // row of slot cells
    // ------------------------------------------------------------------
    assign w_probe[0] = '{active: r_inject, found: 1'b0, idx: '0};

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        irkt_cell #(
            .CELL_IDX (SLOT_IDX_W'(g))
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key      (r_key),
            .i_used     (CNT_W'(r_used)),
            .i_probe    (w_probe[g]),
            .o_probe    (w_probe[g+1]),
            .i_wr       (w_wr),
            .o_press_en (w_press_en[g]),
            .o_rel_en   (w_rel_en[g])
        );
    end

    // ------------------------------------------------------------------
    // finish: state update, table write and result
    // ------------------------------------------------------------------
    assign w_quiet_inc = (r_quiet < QUIET_MAX) ? (r_quiet + 16'd1) : r_quiet;

    always_comb begin
        n_used           = r_used;
        n_held_slot      = r_held_slot;
        n_held_valid     = r_held_valid;
        n_pressed        = r_pressed;
        n_released       = r_released;
        n_quiet          = r_quiet;
        n_event_res      = EV_NONE;
        n_slot           = '0;
        n_action_code    = '0;
        n_released_match = 1'b0;
        w_wr             = '0;

        case (r_kind)
            KIND_TICK: begin
                n_quiet = w_quiet_inc;
                if ((r_pressed != REPEAT_MARK) && (w_quiet_inc > r_timeout)) begin
                    // release event only for a held slot with release enabled
                    if (r_held_valid && w_rel_en[r_held_slot]) begin
                        n_event_res   = EV_RELEASE;
                        // low 5 bits of the held slot
                        n_slot        = 5'(r_held_slot);
                        n_action_code = r_pressed;
                        n_held_valid  = 1'b0;
                    end
                    n_released = r_pressed;
                    n_pressed  = REPEAT_MARK;
                end
            end
            KIND_FRAME: begin
                n_quiet = '0;
                // repeat frames only restart the quiet time
                if (r_key != REPEAT_MARK) begin
                    n_pressed = r_key;
                    if (r_found) begin
                        if (w_press_en[r_found_idx[IW-1:0]]) begin
                            n_event_res   = EV_PRESS;
                            n_slot        = r_found_idx[4:0];
                            n_action_code = r_key;
                        end
                        n_held_slot  = r_found_idx[IW-1:0];
                        n_held_valid = 1'b1;
                    end
                end
            end
            KIND_SET_PRESS, KIND_SET_RELEASE: begin
                if (r_found) begin
                    // known code: update only the addressed mark
                    w_wr.idx       = r_found_idx;
                    w_wr.set_press = w_commit && (r_kind == KIND_SET_PRESS);
                    w_wr.set_rel   = w_commit && (r_kind == KIND_SET_RELEASE);
                    w_wr.press     = r_on;
                    w_wr.rel       = r_on;
                end else if (r_used == CW'(SLOTS)) begin
                    n_event_res = EV_DROPPED;
                end else begin
                    // append, the other mark of a new slot starts off
                    w_wr.idx       = SLOT_IDX_W'(r_used);
                    w_wr.set_code  = w_commit;
                    w_wr.set_press = w_commit;
                    w_wr.set_rel   = w_commit;
                    w_wr.code      = r_key;
                    w_wr.press     = (r_kind == KIND_SET_PRESS) && r_on;
                    w_wr.rel       = (r_kind == KIND_SET_RELEASE) && r_on;
                    n_used         = r_used + CW'(1);
                end
            end
            KIND_QUERY: begin
                if ((r_released != REPEAT_MARK) && (r_key == r_released)) begin
                    n_released_match = 1'b1;
                    n_released       = REPEAT_MARK;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= RESET_TIMEOUT;
        end else if (i_cfg_we) begin
            r_timeout    <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_held_slot  <= '0;
            r_held_valid <= 1'b0;
            r_pressed    <= REPEAT_MARK;
            r_released   <= REPEAT_MARK;
            r_quiet      <= '0;
        end else if (w_commit) begin
            r_used       <= n_used;
            r_held_slot  <= n_held_slot;
            r_held_valid <= n_held_valid;
            r_pressed    <= n_pressed;
            r_released   <= n_released;
            r_quiet      <= n_quiet;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_event_res      <= n_event_res;
            r_slot           <= n_slot;
            r_action_code    <= n_action_code;
            r_held_code      <= n_pressed;
            r_released_match <= n_released_match;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_res      = r_event_res;
    assign o_slot           = r_slot;
    assign o_action_code    = r_action_code;
    assign o_held_code      = r_held_code;
    assign o_released_match = r_released_match;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a held slot always points into the filled part of the table
    a_held_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (CNT_W'(r_held_slot) < CNT_W'(r_used)))
        else $error("held slot beyond fill count");

    // the fill count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_used) <= CNT_W'(SLOTS))
        else $error("fill count beyond table size");

    // the search token leaves the row only while a search is running
    a_probe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_probe[SLOTS].active |-> (r_state == S_SCAN))
        else $error("search token outside of a search");

    // a finished transaction waits while the output register is stalled
    a_fin_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_out_valid && !i_ready) |=> (r_state == S_FIN))
        else $error("result overwrote a stalled output");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ir key press / release tracker. Ticks, frames,
// registrations and release queries are driven over the valid / ready input
// channel. Every accepted transaction runs through a cycle-free predictor
// that keeps its own copy of the slot table, the held key and the quiet
// timer. Each result transaction is compared field by field with the oldest
// pending prediction. Both channels idle at random, and the release timeout
// is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_top import irkt_pkg::*; ();

    localparam int TABLE_SLOTS = 32;
    // frames and registrations walk every slot before the result is ready
    localparam int MAX_LATENCY = TABLE_SLOTS + 3;
    localparam int POOL_SIZE   = 16;

    // kinds that the tracker ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // a few typical remote codes for the directed tests
    localparam logic [31:0] CODE_A = 32'h00FF_A25D;
    localparam logic [31:0] CODE_B = 32'h00FF_629D;
    localparam logic [31:0] CODE_C = 32'h00FF_E21D;
    localparam logic [31:0] CODE_X = 32'h1234_5678;

    typedef struct {
        logic [1:0]  event_res;
        logic [4:0]  slot;
        logic [31:0] action_code;
        logic [31:0] held_code;
        logic        released_match;
    } t_result;

    // dut connections
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_kind;
    logic [31:0] i_key_code;
    logic        i_handler_on;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_event_res;
    logic [4:0]  o_slot;
    logic [31:0] o_action_code;
    logic [31:0] o_held_code;
    logic        o_released_match;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    // tracker state as the predictor sees it
    logic [31:0] key_codes [TABLE_SLOTS];
    bit          press_on [TABLE_SLOTS];
    bit          release_on [TABLE_SLOTS];
    int          used_slots   = 0;
    int          hold_slot    = 0;
    bit          hold_valid   = 1'b0;
    logic [31:0] down_code    = REPEAT_MARK;
    logic [31:0] latched_code = REPEAT_MARK;
    logic [15:0] quiet_count  = '0;
    logic [15:0] timeout_ms   = RESET_TIMEOUT;

    t_result     pending_results [$];
    logic [31:0] code_pool [POOL_SIZE];

    int fail_count    = 0;
    int sent_count    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_left     = 0;

    ir_key_press_release_tracker #(
        .SLOTS(TABLE_SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_key_code       (i_key_code),
        .i_handler_on     (i_handler_on),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_event_res      (o_event_res),
        .o_slot           (o_slot),
        .o_action_code    (o_action_code),
        .o_held_code      (o_held_code),
        .o_released_match (o_released_match),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // slot holding the code, -1 when it is not registered
    function automatic int find_code(input logic [31:0] code);
        for (int i = 0; i < used_slots; i++) begin
            if (key_codes[i] == code)
                return i;
        end
        return -1;
    endfunction

    // expected result of one transaction, advancing the predicted state
    function automatic t_result predict_result(input logic [2:0] kind,
                                               input logic [31:0] code,
                                               input logic mark_on);
        t_result r;
        int      idx;
        r = '{event_res: EV_NONE, slot: '0, action_code: '0, held_code: '0,
              released_match: 1'b0};
        case (kind)
            KIND_TICK: begin
                // quiet timer saturates, so the largest timeout never fires
                if (quiet_count != QUIET_MAX)
                    quiet_count++;
                if (down_code != REPEAT_MARK && quiet_count > timeout_ms) begin
                    if (hold_valid && release_on[hold_slot]) begin
                        r.event_res   = EV_RELEASE;
                        r.slot        = 5'(hold_slot);
                        r.action_code = down_code;
                        hold_valid    = 1'b0;
                    end
                    // latched even when the held slot has release disabled
                    latched_code = down_code;
                    down_code    = REPEAT_MARK;
                end
            end
            KIND_FRAME: begin
                quiet_count = '0;
                if (code != REPEAT_MARK) begin
                    idx       = find_code(code);
                    down_code = code;
                    // an unknown code keeps the old held slot
                    if (idx >= 0) begin
                        if (press_on[idx]) begin
                            r.event_res   = EV_PRESS;
                            r.slot        = 5'(idx);
                            r.action_code = code;
                        end
                        hold_slot  = idx;
                        hold_valid = 1'b1;
                    end
                end
            end
            KIND_SET_PRESS, KIND_SET_RELEASE: begin
                idx = find_code(code);
                if (idx >= 0) begin
                    if (kind == KIND_SET_RELEASE)
                        release_on[idx] = mark_on;
                    else
                        press_on[idx] = mark_on;
                end else if (used_slots >= TABLE_SLOTS) begin
                    r.event_res = EV_DROPPED;
                end else begin
                    // the other mark of a new slot starts cleared
                    key_codes[used_slots]  = code;
                    press_on[used_slots]   = (kind == KIND_SET_RELEASE) ? 1'b0 : mark_on;
                    release_on[used_slots] = (kind == KIND_SET_RELEASE) ? mark_on : 1'b0;
                    used_slots++;
                end
            end
            KIND_QUERY: begin
                // the marker never matches, it stands for an empty latch
                if (latched_code != REPEAT_MARK && code == latched_code) begin
                    r.released_match = 1'b1;
                    latched_code     = REPEAT_MARK;
                end
            end
            default: begin
            end
        endcase
        r.held_code = down_code;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking: results are compared at the rising edge they are taken on,
    // predictions are queued at the rising edge their transaction is taken on
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no transaction pending");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(o_event_res));
                    check_field("slot", 32'(want.slot), 32'(o_slot));
                    check_field("action_code", want.action_code, o_action_code);
                    check_field("held_code", want.held_code, o_held_code);
                    check_field("released_match", 32'(want.released_match),
                                32'(o_released_match));
                end
            end
            if (i_valid && o_ready)
                pending_results.push_back(predict_result(i_kind, i_key_code,
                                                         i_handler_on));
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a long hold-off when one is requested
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // sender side; every task starts and ends on a falling edge
    // ------------------------------------------------------------------------

    // offer one transaction and wait until it is taken
    task automatic send_item(input logic [2:0] kind, input logic [31:0] code,
                             input logic mark_on);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_key_code   <= code;
        i_handler_on <= mark_on;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sent_count++;
        @(negedge i_clk);
    endtask

    // stop offering and wait for every pending result
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // timeout register write, only with the tracker idle
    task automatic write_timeout(input logic [15:0] value);
        wait_results_done();
        repeat (MAX_LATENCY) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        timeout_ms  = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // mostly known remote codes, sometimes anything at all
    function automatic logic [31:0] pick_code();
        if ($urandom_range(4) == 0)
            return $urandom;
        return code_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // one stray transaction of any kind
    task automatic send_random_item();
        int          roll;
        logic [31:0] code;
        roll = $urandom_range(99);
        code = pick_code();
        if (roll < 35)
            send_item(KIND_TICK, $urandom, $urandom_range(1));
        else if (roll < 50)
            send_item(KIND_FRAME, ($urandom_range(4) == 0) ? REPEAT_MARK : code,
                      $urandom_range(1));
        else if (roll < 62)
            send_item(KIND_SET_PRESS, code, $urandom_range(1));
        else if (roll < 74)
            send_item(KIND_SET_RELEASE, code, $urandom_range(1));
        else if (roll < 94)
            send_item(KIND_QUERY, $urandom_range(1) ? latched_code : code,
                      $urandom_range(1));
        else
            send_item(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)), $urandom,
                      $urandom_range(1));
    endtask

    // a key held down: frame, repeats with some ticks, silence, then maybe a query
    task automatic send_key_sequence();
        logic [31:0] code;
        code = pick_code();
        send_item(KIND_FRAME, code, $urandom_range(1));
        repeat ($urandom_range(3)) begin
            if ($urandom_range(1))
                send_item(KIND_FRAME, REPEAT_MARK, $urandom_range(1));
            else
                send_item(KIND_TICK, $urandom, $urandom_range(1));
        end
        repeat ($urandom_range(32'(timeout_ms) + 2)) send_item(KIND_TICK, $urandom, 1'b0);
        if ($urandom_range(2) != 0)
            send_item(KIND_QUERY, $urandom_range(1) ? latched_code : code, 1'b0);
    endtask

    task automatic random_traffic(input int n_items);
        int stop_at;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            if ($urandom_range(99) < 55)
                send_key_sequence();
            else
                send_random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // nothing registered, nothing held
    task automatic test_empty_tracker();
        send_item(KIND_QUERY, 32'h0, 1'b0);
        send_item(KIND_QUERY, REPEAT_MARK, 1'b1);
        send_item(KIND_TICK, 32'h0, 1'b0);
        send_item(KIND_FRAME, REPEAT_MARK, 1'b0);
        send_item(KIND_SPARE_LO, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_SPARE_HI, 32'h0, 1'b0);
    endtask

    // appends and updates of press and release marks
    task automatic test_registration();
        send_item(KIND_SET_PRESS, CODE_A, 1'b1);
        send_item(KIND_SET_RELEASE, CODE_A, 1'b1);
        send_item(KIND_SET_RELEASE, CODE_B, 1'b1);
        send_item(KIND_SET_PRESS, CODE_C, 1'b1);
        send_item(KIND_SET_PRESS, CODE_C, 1'b0);
        send_item(KIND_SET_PRESS, REPEAT_MARK, 1'b1);
        send_item(KIND_SET_RELEASE, 32'h0, 1'b1);
    endtask

    task automatic test_press_release();
        write_timeout(16'd2);
        // press, repeat keeps it held, release after the timeout
        send_item(KIND_FRAME, CODE_A, 1'b0);
        send_item(KIND_TICK, 32'h0, 1'b0);
        send_item(KIND_FRAME, REPEAT_MARK, 1'b0);
        repeat (3) send_item(KIND_TICK, 32'h0, 1'b0);
        send_item(KIND_QUERY, CODE_A, 1'b0);
        send_item(KIND_QUERY, CODE_A, 1'b0);
        // press disabled, then an unknown code keeps the old held slot
        send_item(KIND_FRAME, CODE_C, 1'b0);
        send_item(KIND_FRAME, CODE_X, 1'b0);
        repeat (3) send_item(KIND_TICK, 32'h0, 1'b0);
        send_item(KIND_QUERY, CODE_X, 1'b0);
        // release enabled without press
        send_item(KIND_FRAME, CODE_B, 1'b0);
        repeat (3) send_item(KIND_TICK, 32'h0, 1'b0);
        // unknown code after a release leaves no slot held, so no release event
        send_item(KIND_FRAME, CODE_X, 1'b0);
        repeat (3) send_item(KIND_TICK, 32'h0, 1'b0);
        send_item(KIND_FRAME, 32'h0, 1'b0);
        repeat (3) send_item(KIND_TICK, 32'h0, 1'b0);
    endtask

    // zero, one, and the top of the timeout range
    task automatic test_timeout_extremes();
        set_idling(0, 0);
        write_timeout(16'd0);
        send_item(KIND_FRAME, CODE_A, 1'b0);
        send_item(KIND_TICK, 32'h0, 1'b0);
        write_timeout(16'd1);
        send_item(KIND_FRAME, CODE_A, 1'b0);
        repeat (2) send_item(KIND_TICK, 32'h0, 1'b0);
        // largest timeout, no release within a burst of ticks
        write_timeout(16'hFFFF);
        send_item(KIND_FRAME, CODE_B, 1'b0);
        repeat (40) send_item(KIND_TICK, 32'h0, 1'b0);
        write_timeout(16'hFFFE);
        send_item(KIND_TICK, 32'h0, 1'b0);
        send_item(KIND_QUERY, CODE_B, 1'b0);
    endtask

    task automatic test_random_phases();
        write_timeout(16'd3);
        set_idling(26, 52);
        random_traffic(650);
        write_timeout(16'($urandom_range(12, 1)));
        set_idling(52, 26);
        random_traffic(650);
        write_timeout(16'd6);
        set_idling(0, 0);
        random_traffic(650);
        wait_results_done();
    endtask

    // receiver stalls long enough for the input side to back up
    task automatic test_output_stall();
        set_idling(0, 0);
        hold_req = 400;
        repeat (30) send_random_item();
        wait_results_done();
    endtask

    // fill every slot, then new codes are dropped and old ones still update
    task automatic test_table_full();
        logic [31:0] code;
        set_idling(26, 26);
        while (used_slots < TABLE_SLOTS) begin
            code = $urandom;
            if (find_code(code) < 0 && code != REPEAT_MARK)
                send_item(KIND_SET_PRESS, code, 1'b1);
        end
        send_item(KIND_SET_PRESS, ~key_codes[0], 1'b1);
        send_item(KIND_SET_RELEASE, ~key_codes[0], 1'b1);
        send_item(KIND_SET_RELEASE, key_codes[TABLE_SLOTS - 1], 1'b1);
        send_item(KIND_FRAME, key_codes[TABLE_SLOTS - 1], 1'b0);
        repeat (32'(timeout_ms) + 2) send_item(KIND_TICK, 32'h0, 1'b0);
        wait_results_done();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = KIND_TICK;
        i_key_code   = '0;
        i_handler_on = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        code_pool[0] = CODE_A;
        code_pool[1] = CODE_B;
        code_pool[2] = CODE_C;
        code_pool[3] = 32'h0;
        code_pool[4] = 32'hFFFF_FFFE;
        for (int i = 5; i < POOL_SIZE; i++)
            code_pool[i] = $urandom;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tracker();
        test_registration();
        test_press_release();
        test_timeout_extremes();
        test_random_phases();
        test_output_stall();
        test_table_full();

        // quiet spell to catch any stray result
        wait_results_done();
        repeat (MAX_LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin
        repeat (3_000_000) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/irkt_pkg.sv
src/irkt_cell.sv
src/ir_key_press_release_tracker.sv
verif/tb_top.sv
